>>> rtl/core/knnmv_pkg.sv
// Shared widths, register indexes and controller/datapath bundles for the k-NN vote core.
package knnmv_pkg;

	// Fixed field widths.
	localparam int CLS_W      = 4;
	localparam int DIST_W     = 32;
	localparam int K_W        = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOUR_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THRESHOLD  = CFG_IDX_W'(1);

	// Register reset values.
	localparam logic [K_W-1:0]    K_RESET   = K_W'(5);
	localparam logic [DIST_W-1:0] THR_RESET = '0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;
		logic vote_init;
		logic vote_step;
		logic scan_step;
		logic set_exact;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic exact_hit;
		logic store_empty;
		logic vote_last;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/core/knnmv_if.sv
// Valid/ready channel interfaces for points, results and configuration writes.
interface knnmv_point_if;
	logic                              valid;
	logic                              ready;
	logic [knnmv_pkg::CLS_W-1:0]       point_class;
	logic [knnmv_pkg::DIST_W-1:0]      point_distance;
	logic                              last_point;

	modport source (output valid, output point_class, output point_distance,
		output last_point, input ready);
	modport sink (input valid, input point_class, input point_distance,
		input last_point, output ready);
endinterface

interface knnmv_result_if;
	logic                              valid;
	logic                              ready;
	logic [knnmv_pkg::CLS_W-1:0]       chosen_class;
	logic                              exact_match;

	modport source (output valid, output chosen_class, output exact_match, input ready);
	modport sink (input valid, input chosen_class, input exact_match, output ready);
endinterface

interface knnmv_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [knnmv_pkg::CFG_IDX_W-1:0]   index;
	logic [knnmv_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/knn_majority_vote_core.sv
// Top level of the k-nearest-neighbor majority vote core.
//
//   Channel  Dir  Beat contents                                 Accepted when
//   points   in   point_class, point_distance, last_point       valid && ready
//   result   out  chosen_class, exact_match                     valid && ready
//   cfg      in   index (0 = neighbour_count, 1 = zero_threshold), data   valid && ready
//
// A point beat without last_point is a parallel compare-insert into the store. A last beat
// adds a threshold check, one vote step per voting entry (k, limited to the points stored),
// a scan over min(CLASS_COUNT, 16) classes and an output load.
// When the nearest point is below the threshold, the check goes straight to the load.
// Points are taken again once the result sits in the output register; a second decision
// waits for that register to empty. Reset is asynchronous; cfg is always ready.
module knn_majority_vote_core #(
	parameter int MAX_NEIGHBOURS = 16,
	parameter int CLASS_COUNT    = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	knnmv_point_if.sink     points,
	knnmv_result_if.source  result,
	knnmv_cfg_if.sink       cfg
);

	knnmv_pkg::ctrl_cmd_t  cmd;
	knnmv_pkg::dp_status_t status;
	logic                  in_ready;

	assign points.ready = in_ready;

	// Sequencer.
	knnmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.in_last  (points.last_point),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Store, voting and output registers.
	knnmv_datapath #(
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS),
		.CLASS_COUNT    (CLASS_COUNT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_class (points.point_class),
		.in_dist  (points.point_distance),
		.cmd      (cmd),
		.status   (status),
		.cfg      (cfg),
		.result   (result)
	);

endmodule

>>> rtl/core/knnmv_ctrl.sv
// Controller state machine sequencing insert, threshold check, voting, class scan and output.
module knnmv_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_last,
	output logic                   in_ready,
	input  knnmv_pkg::dp_status_t  status,
	output knnmv_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_VOTE,
		ST_SCAN,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   in_fire;

	assign in_ready = ready_q;
	assign in_fire  = in_valid && ready_q;

	// Command decode from the current state.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.insert = in_fire;
			ST_CHECK: begin
				cmd.set_exact = status.exact_hit;
				cmd.vote_init = !status.exact_hit;
			end
			ST_VOTE:  cmd.vote_step = 1'b1;
			ST_SCAN:  cmd.scan_step = 1'b1;
			ST_LOAD:  cmd.load_out  = status.out_free;
			default:  cmd = '0;
		endcase
	end

	// State register and registered ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && in_last) begin
						state_q <= ST_CHECK;
						ready_q <= 1'b0;
					end
				end
				ST_CHECK: begin
					if (status.exact_hit) begin
						state_q <= ST_LOAD;
					end else if (status.store_empty) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_VOTE;
					end
				end
				ST_VOTE: begin
					if (status.vote_last) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.scan_last) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	// A new beat is only taken while idle.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (state_q == ST_IDLE))
		else $error("input ready outside the idle state");

	// A last beat always starts a decision.
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_last) |=> (state_q == ST_CHECK) && !ready_q)
		else $error("last beat did not start a decision");

	// Output is loaded only when the output register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free && (state_q == ST_LOAD))
		else $error("output loaded while occupied");

endmodule

>>> rtl/core/knnmv_datapath.sv
// Datapath: sorted nearest store, vote counters, class scan, config and output registers.
module knnmv_datapath #(
	parameter int MAX_NEIGHBOURS = 16,
	parameter int CLASS_COUNT    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [knnmv_pkg::CLS_W-1:0]       in_class,
	input  logic [knnmv_pkg::DIST_W-1:0]      in_dist,
	input  knnmv_pkg::ctrl_cmd_t              cmd,
	output knnmv_pkg::dp_status_t             status,
	knnmv_cfg_if.sink                         cfg,
	knnmv_result_if.source                    result
);

	localparam int CLS_W        = knnmv_pkg::CLS_W;
	localparam int DIST_W       = knnmv_pkg::DIST_W;
	localparam int K_W          = knnmv_pkg::K_W;
	localparam int FILL_W       = $clog2(MAX_NEIGHBOURS + 1);
	localparam int KW           = (FILL_W > K_W) ? FILL_W : K_W;
	localparam int SUM_W        = DIST_W + FILL_W;
	localparam int CLS_RANGE    = 1 << CLS_W;
	localparam int VOTE_CLASSES = (CLASS_COUNT < CLS_RANGE) ? CLASS_COUNT : CLS_RANGE;
	localparam int SCAN_W       = $clog2(VOTE_CLASSES);

	// Configuration registers.
	logic [K_W-1:0]    k_q;
	logic [DIST_W-1:0] thr_q;

	// Sorted store, nearest first.
	logic [DIST_W-1:0] dist_q [MAX_NEIGHBOURS];
	logic [CLS_W-1:0]  cls_q  [MAX_NEIGHBOURS];
	logic [FILL_W-1:0] fill_q;

	logic [DIST_W-1:0] ins_dist   [MAX_NEIGHBOURS];
	logic [CLS_W-1:0]  ins_cls    [MAX_NEIGHBOURS];
	logic [DIST_W-1:0] shift_dist [MAX_NEIGHBOURS];
	logic [CLS_W-1:0]  shift_cls  [MAX_NEIGHBOURS];
	logic [MAX_NEIGHBOURS-1:0] stays;

	// Vote counters and scan state.
	logic [FILL_W-1:0] cnt_q [VOTE_CLASSES];
	logic [SUM_W-1:0]  sum_q [VOTE_CLASSES];
	logic [FILL_W-1:0] rem_q;
	logic [SCAN_W-1:0] scan_q;
	logic [FILL_W-1:0] best_cnt_q;
	logic [SUM_W-1:0]  best_sum_q;
	logic [CLS_W-1:0]  best_cls_q;
	logic              exact_q;

	// Output register.
	logic              out_vld_q;
	logic [CLS_W-1:0]  out_cls_q;
	logic              out_exact_q;

	logic [KW-1:0]     k_ext;
	logic [KW-1:0]     k_min1;
	logic [KW-1:0]     k_cap;
	logic [KW-1:0]     fill_ext;
	logic [FILL_W-1:0] k_eff;
	logic [FILL_W-1:0] scan_cnt;
	logic [SUM_W-1:0]  scan_sum;
	logic              scan_take;

	// Per-entry compare-insert and vote shift paths.
	for (genvar g = 0; g < MAX_NEIGHBOURS; g++) begin : g_entry
		assign stays[g] = (FILL_W'(g) < fill_q) && (dist_q[g] <= in_dist);
		if (g == 0) begin : g_head
			assign ins_dist[g] = stays[g] ? dist_q[g] : in_dist;
			assign ins_cls[g]  = stays[g] ? cls_q[g]  : in_class;
		end else begin : g_body
			assign ins_dist[g] = stays[g] ? dist_q[g] : (stays[g-1] ? in_dist : dist_q[g-1]);
			assign ins_cls[g]  = stays[g] ? cls_q[g]  : (stays[g-1] ? in_class : cls_q[g-1]);
		end
		if (g == MAX_NEIGHBOURS - 1) begin : g_tail
			assign shift_dist[g] = '1;
			assign shift_cls[g]  = '0;
		end else begin : g_mid
			assign shift_dist[g] = dist_q[g+1];
			assign shift_cls[g]  = cls_q[g+1];
		end
	end

	// Effective k: k raised to at least one, then limited to the store depth and the fill.
	always_comb begin
		k_ext    = KW'(k_q);
		k_min1   = (k_ext == '0) ? KW'(1) : k_ext;
		k_cap    = (k_min1 > KW'(MAX_NEIGHBOURS)) ? KW'(MAX_NEIGHBOURS) : k_min1;
		fill_ext = KW'(fill_q);
		k_eff    = FILL_W'((k_cap > fill_ext) ? fill_ext : k_cap);
	end

	// Class scan compare: more votes, then smaller distance sum, then lower index.
	assign scan_cnt  = cnt_q[scan_q];
	assign scan_sum  = sum_q[scan_q];
	assign scan_take = (scan_q == '0) || (scan_cnt > best_cnt_q) ||
		((scan_cnt == best_cnt_q) && (scan_sum < best_sum_q));

	// Status to the controller.
	assign status.exact_hit   = (fill_q != '0) && (dist_q[0] < thr_q);
	assign status.store_empty = (k_eff == '0);
	assign status.vote_last   = (rem_q == FILL_W'(1));
	assign status.scan_last   = (scan_q == SCAN_W'(VOTE_CLASSES - 1));
	assign status.out_free    = !out_vld_q || result.ready;

	// Configuration writes; indexes beyond the list are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= knnmv_pkg::K_RESET;
			thr_q <= knnmv_pkg::THR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				knnmv_pkg::CFG_NEIGHBOUR_COUNT: k_q   <= cfg.data[K_W-1:0];
				knnmv_pkg::CFG_ZERO_THRESHOLD:  thr_q <= cfg.data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Store fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.load_out) begin
			fill_q <= '0;
		end else if (cmd.insert) begin
			if (fill_q != FILL_W'(MAX_NEIGHBOURS)) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end else if (cmd.vote_step) begin
			if (fill_q != '0) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	// Store entries: insert in sorted order, or shift toward the head while voting.
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
				dist_q[i] <= ins_dist[i];
				cls_q[i]  <= ins_cls[i];
			end
		end else if (cmd.vote_step) begin
			for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
				dist_q[i] <= shift_dist[i];
				cls_q[i]  <= shift_cls[i];
			end
		end
	end

	// Vote accumulation, one store entry per cycle from the head.
	always_ff @(posedge clk) begin
		if (cmd.vote_init) begin
			for (int j = 0; j < VOTE_CLASSES; j++) begin
				cnt_q[j] <= '0;
				sum_q[j] <= '0;
			end
		end else if (cmd.vote_step) begin
			for (int j = 0; j < VOTE_CLASSES; j++) begin
				if (cls_q[0] == CLS_W'(j)) begin
					cnt_q[j] <= cnt_q[j] + FILL_W'(1);
					sum_q[j] <= sum_q[j] + SUM_W'(dist_q[0]);
				end
			end
		end
	end

	// Vote countdown, class scan and winner registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			scan_q <= '0;
		end else if (cmd.vote_init) begin
			rem_q  <= k_eff;
			scan_q <= '0;
		end else begin
			if (cmd.vote_step) begin
				rem_q <= rem_q - FILL_W'(1);
			end
			if (cmd.scan_step) begin
				scan_q <= status.scan_last ? '0 : scan_q + SCAN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_exact) begin
			best_cls_q <= cls_q[0];
			exact_q    <= 1'b1;
		end else if (cmd.vote_init) begin
			exact_q    <= 1'b0;
		end else if (cmd.scan_step && scan_take) begin
			best_cnt_q <= scan_cnt;
			best_sum_q <= scan_sum;
			best_cls_q <= CLS_W'(scan_q);
		end
	end

	// Output register, freed when the result beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_cls_q   <= best_cls_q;
			out_exact_q <= exact_q;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.chosen_class = out_cls_q;
	assign result.exact_match  = out_exact_q;

	// The fill count never passes the store depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_NEIGHBOURS))
		else $error("store fill count beyond depth");

	// Valid store entries stay sorted by distance.
	for (genvar g = 0; g < MAX_NEIGHBOURS - 1; g++) begin : g_sorted
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			(FILL_W'(g + 1) < fill_q) |-> (dist_q[g] <= dist_q[g+1]))
			else $error("store entries out of order");
	end

	// Voting never runs past the selected neighbours.
	a_vote_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.vote_step |-> (rem_q != '0))
		else $error("vote step with no neighbour left");

	// Loading a result empties the store and presents the result.
	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (fill_q == '0) && out_vld_q)
		else $error("result load did not clear the store");

endmodule
